[rtl/bldc_bemf_commutator_macros.svh]
// Assertion macros shared by the commutator checker.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef BLDC_BEMF_COMMUTATOR_MACROS_SVH
`define BLDC_BEMF_COMMUTATOR_MACROS_SVH

// Condition must hold in the same cycle as the antecedent.
`define BBC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("commutator check failed");

// Condition must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("commutator check failed");

`endif

[rtl/bbc_pkg.sv]
// Shared types, codes and tables of the six-step back-EMF commutator.
// Used by bldc_bemf_commutator and its checker; depends on nothing.
package bbc_pkg;

  // Item kinds carried in the slave tuser.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TURN_DIRECTION    = 2'd0;
  localparam logic [1:0] REG_BEMF_THRESHOLD    = 2'd1;
  localparam logic [1:0] REG_CLOSED_LOCK_LIMIT = 2'd2;
  localparam logic [1:0] REG_OPEN_LOCK_LIMIT   = 2'd3;

  // Turn direction codes; any other code stops the drive.
  localparam logic [1:0] DIR_CW  = 2'd0;
  localparam logic [1:0] DIR_CCW = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  THRESHOLD_RESET   = 8'h80;
  localparam logic [15:0] CLOSED_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] OPEN_LIMIT_RESET   = 16'd800;

  // Channel indexes of the round-robin sampling.
  localparam logic [1:0] CH_U = 2'd0;
  localparam logic [1:0] CH_V = 2'd1;
  localparam logic [1:0] CH_W = 2'd2;

  // Master tdata layout, highest bit first.
  typedef struct packed {
    logic [1:0] pad;
    logic       duty_forced_zero;
    logic [1:0] next_channel_code;
    logic       lock_flag;
    logic       closed_loop_active;
    logic [2:0] commutation_step;
    logic [5:0] switch_enable_mask;
  } result_t;

  // Gate enables for each commutation step; off outside the six steps.
  function automatic logic [5:0] gate_for(input logic [2:0] pos);
    logic [5:0] m;
    case (pos)
      3'd0:    m = 6'b001001;
      3'd1:    m = 6'b100001;
      3'd2:    m = 6'b100100;
      3'd3:    m = 6'b000110;
      3'd4:    m = 6'b010010;
      3'd5:    m = 6'b011000;
      default: m = 6'b000000;
    endcase
    return m;
  endfunction

  // Back-EMF pattern expected at each step, clockwise or counter-clockwise.
  function automatic logic [2:0] expected_bemf(input logic ccw, input logic [2:0] pos);
    logic [2:0] p;
    case ({ccw, pos})
      4'b0_000: p = 3'd6;
      4'b0_001: p = 3'd4;
      4'b0_010: p = 3'd5;
      4'b0_011: p = 3'd1;
      4'b0_100: p = 3'd3;
      4'b0_101: p = 3'd2;
      4'b1_000: p = 3'd2;
      4'b1_001: p = 3'd6;
      4'b1_010: p = 3'd4;
      4'b1_011: p = 3'd5;
      4'b1_100: p = 3'd1;
      4'b1_101: p = 3'd3;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

  // ADC multiplexer code for a channel index.
  function automatic logic [1:0] mux_code(input logic [1:0] idx);
    logic [1:0] c;
    case (idx)
      CH_U:    c = 2'd0;
      CH_V:    c = 2'd1;
      CH_W:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/bldc_bemf_commutator.sv]
// Sensorless six-step BLDC commutator driven by back-EMF sample patterns.
// Depends on bbc_pkg for item codes, tables and the result layout.
//
// Usage:
//   Items arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser).
//   s_tuser carries the item kind: ADC sample, open-loop step, restart or
//   no operation. Every accepted item gives exactly one result transfer on
//   the master stream (m_tvalid, m_tready, m_tdata) holding the gate mask,
//   step, loop and lock status, the next ADC channel and the duty-stop flag.
//   Configuration registers are written through cfg_valid, cfg_index and
//   cfg_data; cfg_ready is always high. Write them only while the block is
//   idle.
//   Throughput is one item per clock while the receiver takes every result.
//   An accepted transfer is captured in the input register, is evaluated
//   against the drive state and captured in the result register, and shows
//   on m_tdata from then on.
//   When the receiver stalls the result register holds its transfer, the
//   input register fills with one more item, and s_tready then falls until
//   the result is taken.
//   Reset (rst, synchronous) empties both registers, stops the drive with
//   the lock flag set, selects channel U and loads the default threshold
//   and lock limits.
module bldc_bemf_commutator
  import bbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] phase_sample, [8] handover_speed_reached
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] switch_enable_mask, [8:6] commutation_step,
                                 // [9] closed_loop_active, [10] lock_flag,
                                 // [12:11] next_channel_code, [13] duty_forced_zero
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [1:0]  turn_direction;
  logic [7:0]  bemf_threshold;
  logic [15:0] closed_lock_limit;
  logic [15:0] open_lock_limit;

  // Input register
  logic        in_valid;
  opcode_t     in_op;
  logic [7:0]  in_sample;
  logic        in_reached;

  // Result register
  logic        out_valid;
  result_t     out_res;

  // Drive state
  logic [1:0]  chan_idx;
  logic [7:0]  levels [3];
  logic [2:0]  step_pos;
  logic [5:0]  gate_mask;
  logic [15:0] closed_cnt;
  logic [15:0] open_cnt;
  logic        closed_mode;
  logic        handover;
  logic        stopped;

  logic [1:0]  chan_idx_next;
  logic [7:0]  levels_next [3];
  logic [2:0]  step_pos_next;
  logic [5:0]  gate_mask_next;
  logic [15:0] closed_cnt_next;
  logic [15:0] open_cnt_next;
  logic        closed_mode_next;
  logic        handover_next;
  logic        stopped_next;
  logic        forced;

  logic        out_free;
  logic        fire;
  logic [1:0]  ch;
  logic [2:0]  bemf;
  logic        match;
  logic        dir_run;
  logic [2:0]  base_pos;
  logic [2:0]  adv_pos;
  result_t     res_next;

  // Handshake: the result register frees when empty or taken, the input
  // register when empty or moving on.
  assign out_free  = !out_valid || m_tready;
  assign fire      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_res;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_direction    <= DIR_CW;
      bemf_threshold    <= THRESHOLD_RESET;
      closed_lock_limit <= CLOSED_LIMIT_RESET;
      open_lock_limit   <= OPEN_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TURN_DIRECTION:    turn_direction    <= cfg_data[1:0];
        REG_BEMF_THRESHOLD:    bemf_threshold    <= cfg_data[7:0];
        REG_CLOSED_LOCK_LIMIT: closed_lock_limit <= cfg_data;
        REG_OPEN_LOCK_LIMIT:   open_lock_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op      <= opcode_t'(s_tuser);
      in_sample  <= s_tdata[7:0];
      in_reached <= s_tdata[8];
    end
  end

  // Evaluation of one item against the drive state.
  always_comb begin
    chan_idx_next    = chan_idx;
    levels_next      = levels;
    step_pos_next    = step_pos;
    gate_mask_next   = gate_mask;
    closed_cnt_next  = closed_cnt;
    open_cnt_next    = open_cnt;
    closed_mode_next = closed_mode;
    handover_next    = handover;
    stopped_next     = stopped;
    forced           = 1'b0;
    dir_run          = (turn_direction == DIR_CW) || (turn_direction == DIR_CCW);
    ch               = (chan_idx == 2'd3) ? CH_W : chan_idx;
    bemf             = {in_sample > bemf_threshold,
                        levels[1] > bemf_threshold,
                        levels[0] > bemf_threshold};
    match            = dir_run && (step_pos < 3'd6) &&
                       (expected_bemf(turn_direction[0], step_pos) == bemf);
    // Only an open-loop step out of the stopped state starts over from step 0.
    base_pos         = (stopped && (in_op == OP_STEP)) ? 3'd0 : step_pos;
    // Clockwise counts up and counter-clockwise down, wrapping over six steps.
    if (turn_direction == DIR_CCW) begin
      adv_pos = (base_pos == 3'd0) ? 3'd5 : base_pos - 3'd1;
    end else begin
      adv_pos = (base_pos >= 3'd5) ? 3'd0 : base_pos + 3'd1;
    end

    case (in_op)
      OP_SAMPLE: begin
        levels_next[ch] = in_sample;
        chan_idx_next   = (ch == CH_W) ? CH_U : ch + 2'd1;
        // The W sample completes a pattern and is compared directly.
        if (ch == CH_W) begin
          if (match && handover) begin
            step_pos_next    = adv_pos;
            gate_mask_next   = gate_for(adv_pos);
            closed_cnt_next  = '0;
            open_cnt_next    = '0;
            closed_mode_next = 1'b1;
          end else if (!closed_mode && handover) begin
            open_cnt_next = open_cnt + 16'd1;
            if (open_cnt > open_lock_limit) begin
              forced = 1'b1;
            end
          end else if (closed_mode) begin
            closed_cnt_next = closed_cnt + 16'd1;
            if (closed_cnt > closed_lock_limit) begin
              forced = 1'b1;
            end
          end
          // Lock: stop the drive and clear both miss counters.
          if (forced) begin
            handover_next    = 1'b0;
            gate_mask_next   = '0;
            closed_mode_next = 1'b0;
            stopped_next     = 1'b1;
            closed_cnt_next  = '0;
            open_cnt_next    = '0;
          end
        end
      end
      OP_STEP: begin
        // Open-loop step, ignored once back-EMF has taken over.
        if (!closed_mode) begin
          stopped_next = 1'b0;
          if (dir_run) begin
            step_pos_next  = adv_pos;
            gate_mask_next = gate_for(adv_pos);
          end else begin
            step_pos_next    = base_pos;
            gate_mask_next   = '0;
            closed_mode_next = 1'b0;
            stopped_next     = 1'b1;
            forced           = 1'b1;
          end
          handover_next = (dir_run && !stopped && handover) || in_reached;
        end
      end
      OP_RESTART: begin
        step_pos_next    = '0;
        gate_mask_next   = '0;
        closed_cnt_next  = '0;
        open_cnt_next    = '0;
        closed_mode_next = 1'b0;
        handover_next    = 1'b0;
        stopped_next     = 1'b0;
        forced           = 1'b1;
      end
      default: ;
    endcase

    res_next.pad                = '0;
    res_next.duty_forced_zero   = forced;
    res_next.next_channel_code  = mux_code(chan_idx_next);
    res_next.lock_flag          = stopped_next;
    res_next.closed_loop_active = closed_mode_next;
    res_next.commutation_step   = step_pos_next;
    res_next.switch_enable_mask = gate_mask_next;
  end

  // Drive state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      chan_idx    <= CH_U;
      levels      <= '{default: '0};
      step_pos    <= '0;
      gate_mask   <= '0;
      closed_cnt  <= '0;
      open_cnt    <= '0;
      closed_mode <= 1'b0;
      handover    <= 1'b0;
      stopped     <= 1'b1;
    end else begin
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        chan_idx    <= chan_idx_next;
        levels      <= levels_next;
        step_pos    <= step_pos_next;
        gate_mask   <= gate_mask_next;
        closed_cnt  <= closed_cnt_next;
        open_cnt    <= open_cnt_next;
        closed_mode <= closed_mode_next;
        handover    <= handover_next;
        stopped     <= stopped_next;
      end
    end
    if (fire) begin
      out_res <= res_next;
    end
  end

endmodule

[rtl/bbc_checker.sv]
// Port-level checks of the commutator, attached to the top level by bind.
// Depends on bbc_pkg for the result layout and on the assertion macro header.
`include "bldc_bemf_commutator_macros.svh"

module bbc_checker
  import bbc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  result_t res;

  assign res = result_t'(m_tdata);

  // A stalled result transfer stays offered unchanged.
  `BBC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // The step position never leaves the six steps.
  `BBC_ASSERT_IMPLY(a_step, clk, rst, m_tvalid, res.commutation_step < 3'd6)
  // The multiplexer is never sent the unused channel code.
  `BBC_ASSERT_IMPLY(a_chan, clk, rst, m_tvalid, res.next_channel_code != 2'd2)
  // Whenever an item forces the duty to zero the gates are all off.
  `BBC_ASSERT_IMPLY(a_off, clk, rst, m_tvalid && res.duty_forced_zero,
                    res.switch_enable_mask == 6'd0)

endmodule

bind bldc_bemf_commutator bbc_checker u_bbc_checker (.*);
